>>> src/framed_byte_deframer_sum_check_macros.svh
// Assertion macros for the framed byte deframer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FRAMED_BYTE_DEFRAMER_SUM_CHECK_MACROS_SVH
`define FRAMED_BYTE_DEFRAMER_SUM_CHECK_MACROS_SVH

// Implication within the same cycle, checked outside reset.
`define FBDSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication from one cycle to the next, checked outside reset.
`define FBDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fbdsc_pkg.sv
// Shared types and constants for the framed byte deframer.
// Depends on nothing; used by the top level.
package fbdsc_pkg;

  localparam int PAYLOAD_LIMIT = 64;
  localparam int LIMIT_EFF     = (PAYLOAD_LIMIT > 64) ? 64 : PAYLOAD_LIMIT;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 6;
  localparam int STORE_DEPTH = 64;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] LEN_LIMIT      = BYTE_W'(LIMIT_EFF);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_EMIT
  } phase_e;

endpackage

>>> src/fbdsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fbdsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/framed_byte_deframer_sum_check.sv
// Channel    | Direction | Handshake               | Payload
// input      | in        | in_valid_i / in_stall_o | rx_byte_i
// output     | out       | out_valid_o / out_stall_i | payload_byte_o, byte_index_o,
//            |           |                         | frame_length_o, last_o
// config     | in        | cfg_we_i                | cfg_data_i (start code)
//
// While receiving, one byte transfer is taken every cycle. Once a frame passes its
// checksum, the input is stalled and the payload is replayed from the store one byte
// at a time: a new read of the payload RAM is issued only after the previous one has
// returned, and output stalls hold the replay back. Reset is asynchronous and active
// low; the payload store needs no clearing pass, since only entries written in the
// current frame are ever read back.
//
// Framed byte deframer with an additive checksum. Depends on fbdsc_pkg, fbdsc_ram
// and framed_byte_deframer_sum_check_macros.svh.
`include "framed_byte_deframer_sum_check_macros.svh"

module framed_byte_deframer_sum_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  fbdsc_pkg::byte_t     cfg_data_i,
  // receive side
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbdsc_pkg::byte_t     rx_byte_i,
  // result side
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbdsc_pkg::byte_t     payload_byte_o,
  output fbdsc_pkg::idx_t      byte_index_o,
  output fbdsc_pkg::idx_t      frame_length_o,
  output logic                 last_o
);
  import fbdsc_pkg::*;

  // Control state.
  phase_e phase_q, phase_d;
  byte_t  start_code_q;
  idx_t   expected_length_q, expected_length_d;
  idx_t   bytes_taken_q, bytes_taken_d;
  byte_t  running_sum_q, running_sum_d;
  idx_t   rd_idx_q, rd_idx_d;
  logic   rd_pend_q;
  logic   out_valid_q, out_valid_d;

  // Output payload register.
  byte_t  out_byte_q;
  idx_t   out_index_q;
  idx_t   out_length_q;
  logic   out_last_q;

  logic   in_fire;
  logic   out_fire;
  logic   issue;
  logic   ram_we;
  byte_t  ram_rdata;

  // Incoming bytes are refused only while a checked frame is being replayed.
  assign in_stall_o = (phase_q == PH_EMIT);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  // A read is issued only when nothing is in flight and the output register will
  // be free when the data returns: either it is empty now or it is being taken now.
  assign issue = (phase_q == PH_EMIT) && !rd_pend_q && (rd_idx_q != expected_length_q)
                 && (!out_valid_q || out_fire);

  assign ram_we = in_fire && (phase_q == PH_DATA);

  fbdsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bytes_taken_q),
    .wdata_i (rx_byte_i),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Next-state logic for the frame sequencer.
  always_comb begin
    phase_d           = phase_q;
    expected_length_d = expected_length_q;
    bytes_taken_d     = bytes_taken_q;
    running_sum_d     = running_sum_q;
    rd_idx_d          = rd_idx_q;

    case (phase_q)
      PH_HUNT: begin
        if (in_fire && (rx_byte_i == start_code_q)) begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_fire) begin
          // The whole byte is checked against the limit before it is narrowed.
          if ((rx_byte_i != '0) && (rx_byte_i < LEN_LIMIT)) begin
            expected_length_d = rx_byte_i[IDX_W-1:0];
            bytes_taken_d     = '0;
            running_sum_d     = '0;
            phase_d           = PH_DATA;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          running_sum_d = running_sum_q + rx_byte_i;
          bytes_taken_d = bytes_taken_q + idx_t'(1);
          if (bytes_taken_d >= expected_length_q) begin
            phase_d = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (in_fire) begin
          // A mismatch drops the frame without a word.
          if (rx_byte_i == running_sum_q) begin
            rd_idx_d = '0;
            phase_d  = PH_EMIT;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      PH_EMIT: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + idx_t'(1);
        end
        // Every byte has been read and handed to the output register, which may
        // still be waiting for its last transfer; the receiver can resume now.
        if ((rd_idx_q == expected_length_q) && !rd_pend_q) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    if (rd_pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PH_HUNT;
      start_code_q      <= START_CODE_RST;
      expected_length_q <= '0;
      bytes_taken_q     <= '0;
      running_sum_q     <= '0;
      rd_idx_q          <= '0;
      rd_pend_q         <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      phase_q           <= phase_d;
      expected_length_q <= expected_length_d;
      bytes_taken_q     <= bytes_taken_d;
      running_sum_q     <= running_sum_d;
      rd_idx_q          <= rd_idx_d;
      rd_pend_q         <= issue;
      out_valid_q       <= out_valid_d;
      if (cfg_we_i) begin
        start_code_q <= cfg_data_i;
      end
    end
  end

  // The read address has already moved on by one when the data comes back.
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_byte_q   <= ram_rdata;
      out_index_q  <= rd_idx_q - idx_t'(1);
      out_length_q <= expected_length_q;
      out_last_q   <= (rd_idx_q == expected_length_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_index_q;
  assign frame_length_o = out_length_q;
  assign last_o         = out_last_q;

  // A read only returns while the payload is being replayed.
  `FBDSC_ASSERT_SAME(a_pend_in_emit, clk_i, rst_ni, rd_pend_q, phase_q == PH_EMIT, "read data returned outside replay")
  // Returning read data always finds the output register free.
  `FBDSC_ASSERT_SAME(a_pend_slot_free, clk_i, rst_ni, rd_pend_q, !out_valid_q, "read data would overwrite a pending output")
  // The byte marked last sits at the end of its frame.
  `FBDSC_ASSERT_SAME(a_last_index, clk_i, rst_ni, out_valid_q && out_last_q, (out_index_q + idx_t'(1)) == out_length_q, "last flag on wrong byte")

endmodule
